/* rtl/wrt_pkg.sv */
// Package for the Wiegand replay transmitter: word types, phase codes and length helpers.
package wrt_pkg;

    localparam int TICK_SHIFT = 6;
    localparam int TIME_W     = 32;
    localparam int LEN_W      = 26;
    localparam int GAP_TRIM_ABOVE = 5;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PULSE = 2'd1,
        PH_GAP   = 2'd2
    } phase_t;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_LOAD = 1'b1
    } func_t;

    typedef struct packed {
        logic              func;
        logic              bit_value;
        logic [TIME_W-1:0] fall_time;
        logic [TIME_W-1:0] rise_time;
        logic [TIME_W-1:0] next_fall_time;
        logic              is_last;
    } in_word_t;

    typedef struct packed {
        logic d0_pull_low;
        logic d1_pull_low;
        logic busy_res;
        logic accepted;
        logic bit_finished;
    } out_word_t;

    // Elapsed time in microseconds, saturated to LEN_W bits, at least 1.
    function automatic logic [LEN_W-1:0] span_us(
        input logic [TIME_W-1:0] from_t,
        input logic [TIME_W-1:0] to_t
    );
        logic [TIME_W-1:0] diff;
        logic [TIME_W-1:0] shifted;
        logic [LEN_W-1:0]  len;
        diff    = to_t - from_t;
        shifted = diff >> TICK_SHIFT;
        if (shifted > TIME_W'(LEN_MAX)) begin
            len = LEN_MAX;
        end else begin
            len = shifted[LEN_W-1:0];
        end
        if (len == '0) begin
            len = LEN_W'(1);
        end
        return len;
    endfunction

    function automatic logic [LEN_W-1:0] gap_us(
        input logic [TIME_W-1:0] rise_t,
        input logic [TIME_W-1:0] next_fall_t,
        input logic              last
    );
        logic [LEN_W-1:0] gap;
        if (last) begin
            gap = LEN_W'(1);
        end else begin
            gap = span_us(rise_t, next_fall_t);
            if (gap > LEN_W'(GAP_TRIM_ABOVE)) begin
                gap = gap - LEN_W'(1);
            end
        end
        return gap;
    endfunction

endpackage

/* rtl/wiegand_replay_transmitter_core.sv */
// Wiegand replay transmitter: sequences captured bits as D0/D1 pulse and gap ticks.
// One word is taken per clock cycle when ready. Each word gives one result word in the
// next cycle, held in a single output register; a new word is taken whenever that register
// is empty or is being drained in the same cycle. Bit words load the pulse and gap lengths
// in microseconds ((time difference) >> TICK_SHIFT, at least 1); tick words count them
// down. A bit word that arrives while a pulse or gap runs is refused and flagged.
module wiegand_replay_transmitter_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wrt_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wrt_pkg::out_word_t m_data
);
    import wrt_pkg::*;

    phase_t           phase_reg, phase_next;
    logic             line_sel_reg, line_sel_next;
    logic [LEN_W-1:0] ticks_left_reg, ticks_left_next;
    logic [LEN_W-1:0] gap_len_reg, gap_len_next;
    logic             accepted_next;
    logic             finished_next;
    logic             m_valid_reg;
    out_word_t        m_data_reg, m_data_next;
    logic [LEN_W-1:0] ticks_dec;
    logic             busy;
    logic             s_take;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_take  = s_valid && s_ready;
    assign busy    = (phase_reg == PH_PULSE) || (phase_reg == PH_GAP);
    assign ticks_dec = ticks_left_reg - LEN_W'(1);

    // next state
    always_comb begin
        phase_next      = phase_reg;
        line_sel_next   = line_sel_reg;
        ticks_left_next = ticks_left_reg;
        gap_len_next    = gap_len_reg;
        accepted_next   = 1'b0;
        finished_next   = 1'b0;
        if (s_data.func == FUNC_LOAD) begin
            if (!busy) begin
                ticks_left_next = span_us(s_data.fall_time, s_data.rise_time);
                gap_len_next    = gap_us(s_data.rise_time, s_data.next_fall_time,
                                         s_data.is_last);
                line_sel_next   = s_data.bit_value;
                phase_next      = PH_PULSE;
                accepted_next   = 1'b1;
            end
        end else begin
            unique case (phase_reg)
                PH_PULSE: begin
                    ticks_left_next = ticks_dec;
                    if (ticks_dec == '0) begin
                        phase_next      = PH_GAP;
                        ticks_left_next = gap_len_reg;
                    end
                end
                PH_GAP: begin
                    ticks_left_next = ticks_dec;
                    if (ticks_dec == '0) begin
                        phase_next    = PH_IDLE;
                        finished_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result word
    always_comb begin
        m_data_next.d0_pull_low  = (phase_next == PH_PULSE) && !line_sel_next;
        m_data_next.d1_pull_low  = (phase_next == PH_PULSE) && line_sel_next;
        m_data_next.busy_res     = (phase_next == PH_PULSE) || (phase_next == PH_GAP);
        m_data_next.accepted     = accepted_next;
        m_data_next.bit_finished = finished_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            line_sel_reg   <= 1'b0;
            ticks_left_reg <= '0;
            gap_len_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_take) begin
                phase_reg      <= phase_next;
                line_sel_reg   <= line_sel_next;
                ticks_left_reg <= ticks_left_next;
                gap_len_reg    <= gap_len_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_load_idle_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && s_data.func == FUNC_LOAD && !busy |=> m_valid && m_data.accepted)
        else $error("bit word taken while idle was not accepted");

    a_busy_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |=> m_data.busy_res == ((phase_reg == PH_PULSE) || (phase_reg == PH_GAP)))
        else $error("busy_res disagrees with phase");

    a_one_line_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.d0_pull_low && m_data.d1_pull_low))
        else $error("both lines pulled low");

    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && s_data.func == FUNC_TICK && phase_reg == PH_GAP && ticks_dec == '0
        |=> phase_reg == PH_IDLE && m_data.bit_finished && !m_data.busy_res)
        else $error("gap end did not return to idle");

endmodule

/* tb/tb_wiegand_replay_transmitter_core.sv */
// Testbench for the Wiegand replay transmitter core: random and directed words, line prediction.
`timescale 1ns / 100ps

module tb_wiegand_replay_transmitter_core;
    import wrt_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int WORD_TARGET  = 1050;
    localparam int HOLD_CYCLES  = 60;
    localparam int IDLE_PCT     = 8;
    localparam int REPORT_MAX   = 10;

    class wiegand_line_tracker;
        phase_t           ph;
        logic             line_sel;
        logic [LEN_W-1:0] ticks_left;
        logic [LEN_W-1:0] gap_len;
        out_word_t        line_states_q[$];
        int               mismatch_cnt;
        int               orphan_cnt;
        int               checked_cnt;
        int               loads_taken;
        int               loads_refused;
        int               bits_done;

        function new();
            ph = PH_IDLE;
            line_sel = 1'b0;
            ticks_left = '0;
            gap_len = '0;
        endfunction

        function bit is_busy();
            return ph == PH_PULSE || ph == PH_GAP;
        endfunction

        function int pending();
            return line_states_q.size();
        endfunction

        static function logic [LEN_W-1:0] elapsed_us(input logic [TIME_W-1:0] t0,
                                                      input logic [TIME_W-1:0] t1);
            logic [TIME_W-1:0] d;
            d = (t1 - t0) >> TICK_SHIFT;
            if (d > TIME_W'(LEN_MAX)) d = TIME_W'(LEN_MAX);
            if (d == '0) d = TIME_W'(1);
            return d[LEN_W-1:0];
        endfunction

        function void note_word(input in_word_t w);
            out_word_t        r;
            logic [LEN_W-1:0] g;
            r = '0;
            if (w.func == FUNC_LOAD) begin
                if (!is_busy()) begin
                    ticks_left = elapsed_us(w.fall_time, w.rise_time);
                    if (w.is_last) begin
                        g = LEN_W'(1);
                    end else begin
                        g = elapsed_us(w.rise_time, w.next_fall_time);
                        if (g > LEN_W'(GAP_TRIM_ABOVE)) g = g - LEN_W'(1);
                    end
                    gap_len = g;
                    line_sel = w.bit_value;
                    ph = PH_PULSE;
                    r.accepted = 1'b1;
                    loads_taken++;
                end else begin
                    loads_refused++;
                end
            end else if (ph == PH_PULSE) begin
                ticks_left = ticks_left - LEN_W'(1);
                if (ticks_left == '0) begin
                    ph = PH_GAP;
                    ticks_left = gap_len;
                end
            end else if (ph == PH_GAP) begin
                ticks_left = ticks_left - LEN_W'(1);
                if (ticks_left == '0) begin
                    ph = PH_IDLE;
                    r.bit_finished = 1'b1;
                    bits_done++;
                end
            end
            r.d0_pull_low = (ph == PH_PULSE) && !line_sel;
            r.d1_pull_low = (ph == PH_PULSE) && line_sel;
            r.busy_res    = is_busy();
            line_states_q.push_back(r);
        endfunction

        function void check_word(input out_word_t got);
            out_word_t want;
            if (line_states_q.size() == 0) begin
                orphan_cnt++;
                if (mismatch_cnt + orphan_cnt <= REPORT_MAX)
                    $display("unexpected result word %b at %0t", got, $realtime);
                return;
            end
            want = line_states_q.pop_front();
            checked_cnt++;
            if (got.d0_pull_low !== want.d0_pull_low || got.d1_pull_low !== want.d1_pull_low ||
                got.busy_res !== want.busy_res || got.accepted !== want.accepted ||
                got.bit_finished !== want.bit_finished) begin
                mismatch_cnt++;
                if (mismatch_cnt + orphan_cnt <= REPORT_MAX)
                    $display("mismatch at %0t: d0/d1/busy/acc/fin want %b%b%b%b%b got %b%b%b%b%b",
                             $realtime, want.d0_pull_low, want.d1_pull_low, want.busy_res,
                             want.accepted, want.bit_finished, got.d0_pull_low,
                             got.d1_pull_low, got.busy_res, got.accepted, got.bit_finished);
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    wiegand_line_tracker tracker;
    int  cycle_cnt = 0;
    int  sent_cnt = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_taken = 1'b0;

    wiegand_replay_transmitter_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) tracker.check_word(m_data);
            if (s_valid && s_ready) tracker.note_word(s_data);
        end
    end

    // result side: random stalls plus one long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic in_word_t random_tick();
        in_word_t w;
        w.func = FUNC_TICK;
        w.bit_value = 1'($urandom_range(1));
        w.fall_time = $urandom;
        w.rise_time = $urandom;
        w.next_fall_time = $urandom;
        w.is_last = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic in_word_t random_load();
        in_word_t w;
        w = random_tick();
        w.func = FUNC_LOAD;
        return w;
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input in_word_t w);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        sent_cnt++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic bit_v, input logic [TIME_W-1:0] fall,
                              input logic [TIME_W-1:0] pulse_diff,
                              input logic [TIME_W-1:0] gap_diff, input logic last,
                              input bit refuse_first, input int noise_pct);
        in_word_t w;
        w.func = FUNC_LOAD;
        w.bit_value = bit_v;
        w.fall_time = fall;
        w.rise_time = fall + pulse_diff;
        w.next_fall_time = w.rise_time + gap_diff;
        w.is_last = last;
        send_word(w);
        if (refuse_first) send_word(random_load());
        while (tracker.is_busy()) begin
            if ($urandom_range(99) < noise_pct) send_word(random_load());
            else send_word(random_tick());
        end
    endtask

    function automatic logic [TIME_W-1:0] random_span(input int long_pct, input int long_max);
        int n;
        n = ($urandom_range(99) < long_pct) ? $urandom_range(9, long_max) : $urandom_range(0, 8);
        return TIME_W'(n * 64 + $urandom_range(0, 63));
    endfunction

    initial begin
        bit drained_once;
        drained_once = 1'b0;
        tracker = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: idle tick, shortest lengths, wrap, gap trim edge, busy refusal
        send_word(random_tick());
        send_frame(1'b0, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0, 0);
        send_frame(1'b1, 32'hFFFF_FFC0, 32'h80, 32'd384, 1'b0, 1'b1, 0);
        send_frame(1'b0, 32'hFFFF_FFFF, 32'd63, 32'd383, 1'b0, 1'b0, 0);
        send_frame(1'b1, $urandom, 32'd64, 32'h0, 1'b0, 1'b0, 0);

        while (sent_cnt < WORD_TARGET) begin
            if (sent_cnt >= 300) hold_req = 1'b1;
            if (!drained_once && sent_cnt >= 650) begin
                drained_once = 1'b1;
                s_valid <= 1'b0;
                do @(negedge aclk); while (tracker.pending() != 0);
            end
            calm = (sent_cnt >= 420 && sent_cnt < 560);
            if ($urandom_range(99) < 6)
                send_word(random_tick());
            else
                send_frame(1'($urandom_range(1)), $urandom, random_span(5, 40),
                           random_span(10, 40), ($urandom_range(99) < 20), 1'b0, 5);
        end
        calm = 1'b0;
        s_valid <= 1'b0;
        do @(negedge aclk); while (tracker.pending() != 0);
        repeat (8) @(negedge aclk);

        $display("%0d words sent: %0d bits loaded, %0d refused while busy, %0d bits completed",
                 sent_cnt, tracker.loads_taken, tracker.loads_refused, tracker.bits_done);
        $display("%0d result words checked, %0d mismatches, %0d unexpected",
                 tracker.checked_cnt, tracker.mismatch_cnt, tracker.orphan_cnt);
        if (tracker.mismatch_cnt == 0 && tracker.orphan_cnt == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
